@@ hw/rtl/lda_topic_gibbs_sampler_defines.svh @@
// Assertion macros for the topic sampler checker.
`ifndef LDA_TOPIC_GIBBS_SAMPLER_DEFINES_SVH
`define LDA_TOPIC_GIBBS_SAMPLER_DEFINES_SVH
// Assert that an antecedent implies a consequent on the next edge.
`define LTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
// Assert that an antecedent implies a consequent in the same cycle.
`define LTS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`endif

@@ hw/rtl/lts_pkg.sv @@
// Package for the topic sampler: sizes, request kinds, states, command types.
package lts_pkg;
  localparam int NumTopics  = 16;
  localparam int VocabSize  = 1024;
  localparam int NumDocs    = 256;
  localparam int WeightBits = 16;
  localparam int CountBits  = 16;

  localparam int KindW    = 3;
  localparam int TermW    = 10;
  localparam int DocW     = 8;
  localparam int TopicW   = 4;
  localparam int ValueW   = 16;
  localparam int UniformW = 16;

  typedef enum logic [2:0] {
    KIND_WR_DOC_WEIGHT  = 3'd0,
    KIND_WR_TERM_WEIGHT = 3'd1,
    KIND_WR_TERM_COUNT  = 3'd2,
    KIND_WR_DOC_COUNT   = 3'd3,
    KIND_SAMPLE         = 3'd4,
    KIND_READ           = 3'd5
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_OLD,
    ST_DEC,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_THRESH,
    ST_SEARCH,
    ST_RD_NEW,
    ST_INC,
    ST_RD_OUT,
    ST_OUT,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic load;         // capture request
    logic wr_dw;
    logic wr_tw;
    logic wr_tc;
    logic wr_dc;
    logic rd_cnt_old;   // read counts at old topic
    logic dec;          // write back decremented counts
    logic scan_start;
    logic scan_step;
    logic scan_last;
    logic thresh;
    logic search_start;
    logic search_step;
    logic rd_cnt_new;
    logic inc;
    logic rd_cnt_out;
    logic out_load;     // present result
  } cmd_t;

  typedef struct packed {
    logic ok;
    logic kind_sample;
    logic kind_read;
    logic kind_write;
    logic scan_done;
    logic search_done;
  } stat_t;
endpackage

@@ hw/rtl/lts_if.sv @@
// Valid/ready channel interfaces for requests and results.
interface lts_req_if;
  logic                       valid;
  logic                       ready;
  logic [lts_pkg::KindW-1:0]    kind;
  logic [lts_pkg::TermW-1:0]    term;
  logic [lts_pkg::DocW-1:0]     doc;
  logic [lts_pkg::TopicW-1:0]   topic;
  logic [lts_pkg::ValueW-1:0]   value;
  logic [lts_pkg::UniformW-1:0] uniform;
  modport source (output valid, kind, term, doc, topic, value, uniform, input ready);
  modport sink (input valid, kind, term, doc, topic, value, uniform, output ready);
endinterface

interface lts_rsp_if;
  logic                     valid;
  logic                     ready;
  logic [lts_pkg::TopicW-1:0] new_topic;
  logic                     picked;
  logic [15:0]              term_count;
  logic [15:0]              doc_count;
  modport source (output valid, new_topic, picked, term_count, doc_count, input ready);
  modport sink (input valid, new_topic, picked, term_count, doc_count, output ready);
endinterface

@@ hw/rtl/lts_ctrl.sv @@
// Controller state machine of the topic sampler.
module lts_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  lts_pkg::stat_t stat,
  output lts_pkg::cmd_t  cmd
);
  lts_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lts_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      lts_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = lts_pkg::ST_RD_OLD;
        end
      end
      lts_pkg::ST_RD_OLD: begin
        // writes finish here; reads and samples fetch old-topic counts
        if (stat.kind_write) begin
          cmd.wr_dw  = 1'b1;
          cmd.wr_tw  = 1'b1;
          cmd.wr_tc  = 1'b1;
          cmd.wr_dc  = 1'b1;
          state_next = lts_pkg::ST_IDLE;
        end else if (stat.kind_read || (stat.kind_sample && !stat.ok)) begin
          cmd.rd_cnt_out = 1'b1;
          state_next     = lts_pkg::ST_RD_OUT;
        end else if (stat.kind_sample) begin
          cmd.rd_cnt_old = 1'b1;
          state_next     = lts_pkg::ST_DEC;
        end else begin
          state_next = lts_pkg::ST_IDLE;
        end
      end
      lts_pkg::ST_DEC: begin
        cmd.dec        = 1'b1;
        cmd.scan_start = 1'b1;
        state_next     = lts_pkg::ST_SCAN;
      end
      lts_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) state_next = lts_pkg::ST_SCAN_LAST;
      end
      lts_pkg::ST_SCAN_LAST: begin
        cmd.scan_last = 1'b1;
        state_next    = lts_pkg::ST_THRESH;
      end
      lts_pkg::ST_THRESH: begin
        cmd.thresh       = 1'b1;
        cmd.search_start = 1'b1;
        state_next       = lts_pkg::ST_SEARCH;
      end
      lts_pkg::ST_SEARCH: begin
        cmd.search_step = 1'b1;
        if (stat.search_done) state_next = lts_pkg::ST_RD_NEW;
      end
      lts_pkg::ST_RD_NEW: begin
        cmd.rd_cnt_new = 1'b1;
        state_next     = lts_pkg::ST_INC;
      end
      lts_pkg::ST_INC: begin
        // re-read the incremented counts before presenting them
        cmd.inc    = 1'b1;
        state_next = lts_pkg::ST_RD_OUT;
      end
      lts_pkg::ST_RD_OUT: begin
        state_next = lts_pkg::ST_OUT;
      end
      lts_pkg::ST_OUT: begin
        cmd.out_load = 1'b1;
        state_next   = lts_pkg::ST_HOLD;
      end
      lts_pkg::ST_HOLD: begin
        out_valid = 1'b1;
        if (out_ready) state_next = lts_pkg::ST_IDLE;
      end
      default: state_next = lts_pkg::ST_IDLE;
    endcase
  end
endmodule

@@ hw/rtl/lts_datapath.sv @@
// Datapath of the topic sampler: weight and count memories, accumulator, search.
module lts_datapath #(
  parameter int NUM_TOPICS  = lts_pkg::NumTopics,
  parameter int VOCAB_SIZE  = lts_pkg::VocabSize,
  parameter int NUM_DOCS    = lts_pkg::NumDocs,
  parameter int WEIGHT_BITS = lts_pkg::WeightBits,
  parameter int COUNT_BITS  = lts_pkg::CountBits
) (
  input  logic                           clk,
  input  logic [lts_pkg::KindW-1:0]      kind,
  input  logic [lts_pkg::TermW-1:0]      term,
  input  logic [lts_pkg::DocW-1:0]       doc,
  input  logic [lts_pkg::TopicW-1:0]     topic,
  input  logic [lts_pkg::ValueW-1:0]     value,
  input  logic [lts_pkg::UniformW-1:0]   uniform,
  input  lts_pkg::cmd_t                  cmd,
  output lts_pkg::stat_t                 stat,
  output logic [lts_pkg::TopicW-1:0]     new_topic,
  output logic                           picked,
  output logic [15:0]                    term_count,
  output logic [15:0]                    doc_count
);
  localparam int TW       = (NUM_TOPICS > 1) ? $clog2(NUM_TOPICS) : 1;
  localparam int VW       = (VOCAB_SIZE > 1) ? $clog2(VOCAB_SIZE) : 1;
  localparam int DW       = (NUM_DOCS > 1) ? $clog2(NUM_DOCS) : 1;
  localparam int DT_DEPTH = NUM_DOCS * NUM_TOPICS;
  localparam int TT_DEPTH = NUM_TOPICS * VOCAB_SIZE;
  localparam int DTA      = $clog2(DT_DEPTH);
  localparam int TTA      = $clog2(TT_DEPTH);
  localparam int PW       = 2 * WEIGHT_BITS;
  localparam int SW       = PW + TW + 1;          // running sum width
  localparam int XW       = SW + lts_pkg::UniformW; // scaled compare width
  localparam int IW       = 32;                   // wide index arithmetic

  logic [WEIGHT_BITS-1:0] dw_mem [DT_DEPTH];
  logic [WEIGHT_BITS-1:0] tw_mem [TT_DEPTH];
  logic [COUNT_BITS-1:0]  tc_mem [TT_DEPTH];
  logic [COUNT_BITS-1:0]  dc_mem [DT_DEPTH];
  logic [SW-1:0]          cum_mem [NUM_TOPICS];

  // captured request
  logic [lts_pkg::KindW-1:0]    r_kind;
  logic [lts_pkg::TermW-1:0]    r_term;
  logic [lts_pkg::DocW-1:0]     r_doc;
  logic [lts_pkg::TopicW-1:0]   r_topic;
  logic [lts_pkg::ValueW-1:0]   r_value;
  logic [lts_pkg::UniformW-1:0] r_uni;
  logic                         r_ok;

  logic               ok_in;
  logic [TW-1:0]      sel;        // topic used for count access
  logic [DTA-1:0]     dt_addr;
  logic [TTA-1:0]     tt_addr;
  logic [TW-1:0]      scan_k, scan_k_d, search_k;
  logic               scan_v;
  logic [DTA-1:0]     dt_scan;
  logic [TTA-1:0]     tt_scan;
  logic [WEIGHT_BITS-1:0] th_q, ph_q;
  logic [SW-1:0]      run;
  logic [XW-1:0]      thr;
  logic [SW-1:0]      cum_q;
  logic               cum_v;
  logic [TW-1:0]      cum_k;
  logic               found;
  logic [TW-1:0]      chosen;
  logic [COUNT_BITS-1:0] tc_q, dc_q;
  logic [COUNT_BITS-1:0] tc_upd, dc_upd;

  localparam logic [COUNT_BITS-1:0] CntMax = '1;

  always_comb begin
    ok_in = (IW'(term) < IW'(VOCAB_SIZE)) && (IW'(doc) < IW'(NUM_DOCS)) &&
            (IW'(topic) < IW'(NUM_TOPICS));
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_kind  <= kind;
      r_term  <= term;
      r_doc   <= doc;
      r_topic <= topic;
      r_value <= value;
      r_uni   <= uniform;
      r_ok    <= ok_in;
    end
  end

  assign stat.ok          = r_ok;
  assign stat.kind_sample = (r_kind == lts_pkg::KIND_SAMPLE);
  assign stat.kind_read   = (r_kind == lts_pkg::KIND_READ);
  assign stat.kind_write  = (r_kind == lts_pkg::KIND_WR_DOC_WEIGHT) ||
                            (r_kind == lts_pkg::KIND_WR_TERM_WEIGHT) ||
                            (r_kind == lts_pkg::KIND_WR_TERM_COUNT) ||
                            (r_kind == lts_pkg::KIND_WR_DOC_COUNT);
  assign stat.scan_done   = (scan_k == TW'(NUM_TOPICS - 1));
  // last topic is done once its running sum is on the compare
  assign stat.search_done = found || (cum_v && (search_k == TW'(NUM_TOPICS - 1)));

  // count-access topic: request topic until the search replaces it
  always_comb begin
    sel     = chosen;
    dt_addr = DTA'(IW'(r_doc) * IW'(NUM_TOPICS) + IW'(sel));
    tt_addr = TTA'(IW'(sel) * IW'(VOCAB_SIZE) + IW'(r_term));
    dt_scan = DTA'(IW'(r_doc) * IW'(NUM_TOPICS) + IW'(scan_k));
    tt_scan = TTA'(IW'(scan_k) * IW'(VOCAB_SIZE) + IW'(r_term));
  end

  // weight memories: write port and scan read port
  always_ff @(posedge clk) begin
    if (cmd.wr_dw && r_ok && r_kind == lts_pkg::KIND_WR_DOC_WEIGHT)
      dw_mem[dt_addr] <= WEIGHT_BITS'(r_value);
    th_q <= dw_mem[dt_scan];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_tw && r_ok && r_kind == lts_pkg::KIND_WR_TERM_WEIGHT)
      tw_mem[tt_addr] <= WEIGHT_BITS'(r_value);
    ph_q <= tw_mem[tt_scan];
  end

  // count memories: one write and one read port each
  always_comb begin
    tc_upd = (tc_q == '0) ? '0 : tc_q - 1'b1;
    dc_upd = (dc_q == '0) ? '0 : dc_q - 1'b1;
    if (cmd.inc) begin
      tc_upd = (tc_q == CntMax) ? CntMax : tc_q + 1'b1;
      dc_upd = (dc_q == CntMax) ? CntMax : dc_q + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_tc && r_ok && r_kind == lts_pkg::KIND_WR_TERM_COUNT)
      tc_mem[tt_addr] <= COUNT_BITS'(r_value);
    else if (cmd.dec || cmd.inc)
      tc_mem[tt_addr] <= tc_upd;
    tc_q <= tc_mem[tt_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_dc && r_ok && r_kind == lts_pkg::KIND_WR_DOC_COUNT)
      dc_mem[dt_addr] <= COUNT_BITS'(r_value);
    else if (cmd.dec || cmd.inc)
      dc_mem[dt_addr] <= dc_upd;
    dc_q <= dc_mem[dt_addr];
  end

  // scan: address topic k, then accumulate its product in the cycle after
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_k <= '0;
      scan_v <= 1'b0;
      run    <= '0;
    end else if (cmd.scan_step || cmd.scan_last) begin
      if (!stat.scan_done) scan_k <= scan_k + 1'b1;
      scan_k_d <= scan_k;
      scan_v   <= cmd.scan_step;
      if (scan_v) begin
        run <= run + SW'(th_q * ph_q);
        cum_mem[scan_k_d] <= run + SW'(th_q * ph_q);
      end
    end else if (scan_v) begin
      scan_v <= 1'b0;
      run    <= run + SW'(th_q * ph_q);
      cum_mem[scan_k_d] <= run + SW'(th_q * ph_q);
    end
  end

  // threshold uniform * total, then a search over stored running sums
  always_ff @(posedge clk) begin
    if (cmd.thresh) thr <= XW'(run) * XW'(r_uni);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      chosen <= TW'(topic);
    end else if (cmd.search_start) begin
      search_k <= '0;
      found    <= 1'b0;
      chosen   <= TW'(r_topic);
      cum_v    <= 1'b0;
    end else if (cmd.search_step) begin
      if (!cum_v) begin
        cum_q <= cum_mem[search_k];
        cum_k <= search_k;
        cum_v <= 1'b1;
      end else begin
        if ({cum_q, 16'b0} > thr) begin
          found  <= 1'b1;
          chosen <= cum_k;
        end else begin
          cum_v    <= 1'b0;
          search_k <= search_k + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      picked <= 1'b0;
    end
    if (cmd.out_load) begin
      new_topic  <= (stat.kind_sample && r_ok) ? lts_pkg::TopicW'(chosen) : r_topic;
      picked     <= stat.kind_sample && r_ok && found;
      term_count <= r_ok ? 16'(tc_q) : '0;
      doc_count  <= r_ok ? 16'(dc_q) : '0;
    end
  end

  logic unused;
  assign unused = ^{dt_scan[0], DW, VW, cmd.rd_cnt_old, cmd.rd_cnt_new, cmd.rd_cnt_out};
endmodule

@@ hw/rtl/lda_topic_gibbs_sampler.sv @@
// Top level of the LDA Gibbs topic sampler.
// Valid sample requests scan, set a threshold and search before the result: the scan reads
// one topic per cycle from both weight memories, and the search tests one stored running
// sum at a time (a memory read, then the compare); each count update is a read then a
// write on a count memory whose read and write ports share one address, and the updated
// counts are read once more before the result.
// One request is in work at a time; the result waits in its register until taken.
module lda_topic_gibbs_sampler #(
  parameter int NUM_TOPICS  = lts_pkg::NumTopics,
  parameter int VOCAB_SIZE  = lts_pkg::VocabSize,
  parameter int NUM_DOCS    = lts_pkg::NumDocs,
  parameter int WEIGHT_BITS = lts_pkg::WeightBits,
  parameter int COUNT_BITS  = lts_pkg::CountBits
) (
  input logic         clk,
  input logic         rst,
  lts_req_if.sink     req,
  lts_rsp_if.source   rsp
);
  lts_pkg::cmd_t  cmd;
  lts_pkg::stat_t stat;

  lts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lts_datapath #(
    .NUM_TOPICS  (NUM_TOPICS),
    .VOCAB_SIZE  (VOCAB_SIZE),
    .NUM_DOCS    (NUM_DOCS),
    .WEIGHT_BITS (WEIGHT_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dp (
    .clk        (clk),
    .kind       (req.kind),
    .term       (req.term),
    .doc        (req.doc),
    .topic      (req.topic),
    .value      (req.value),
    .uniform    (req.uniform),
    .cmd        (cmd),
    .stat       (stat),
    .new_topic  (rsp.new_topic),
    .picked     (rsp.picked),
    .term_count (rsp.term_count),
    .doc_count  (rsp.doc_count)
  );
endmodule

@@ hw/rtl/lts_checker.sv @@
// Port checker for the topic sampler, bound to the top level.
`include "lda_topic_gibbs_sampler_defines.svh"
module lts_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [3:0]  new_topic,
  input logic        picked
);
  // one request at a time: no intake while a result is shown
  `LTS_ASSERT_SAME(a_no_overlap, clk, rst, rsp_valid, !req_ready)
  // an accepted request closes intake on the next cycle
  `LTS_ASSERT_NEXT(a_intake_close, clk, rst, req_valid && req_ready, !req_ready)
  // a result taken returns the block to idle
  `LTS_ASSERT_NEXT(a_ret_idle, clk, rst, rsp_valid && rsp_ready, !rsp_valid)
  // a stalled result holds
  `LTS_ASSERT_NEXT(a_hold, clk, rst, rsp_valid && !rsp_ready,
    rsp_valid && $stable(new_topic) && $stable(picked))
endmodule

bind lda_topic_gibbs_sampler lts_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .new_topic (rsp.new_topic),
  .picked    (rsp.picked)
);

@@ tb/sv/lda_topic_gibbs_sampler_tb.sv @@
// Self-checking testbench for the LDA Gibbs topic sampler.
`timescale 1ns / 100ps

module lda_topic_gibbs_sampler_tb;
  localparam int RandItems  = 340;
  localparam int CycleLimit = 400000;
  localparam int LongHold   = 400;

  typedef struct {
    logic [lts_pkg::KindW-1:0]    kind;
    logic [lts_pkg::TermW-1:0]    term;
    logic [lts_pkg::DocW-1:0]     doc;
    logic [lts_pkg::TopicW-1:0]   topic;
    logic [lts_pkg::ValueW-1:0]   value;
    logic [lts_pkg::UniformW-1:0] uniform;
    bit                           drain;   // wait for all results before offering
  } request_t;

  typedef struct {
    logic [lts_pkg::TopicW-1:0] new_topic;
    logic                       picked;
    logic [15:0]                term_count;
    logic [15:0]                doc_count;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lts_req_if req_ch ();
  lts_rsp_if rsp_ch ();

  lda_topic_gibbs_sampler dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always #5 clk = ~clk;

  // Shadow copies of the four tables.
  logic [15:0] doc_wt   [lts_pkg::NumDocs*lts_pkg::NumTopics];
  logic [15:0] term_wt  [lts_pkg::NumTopics*lts_pkg::VocabSize];
  logic [15:0] term_cnt [lts_pkg::NumTopics*lts_pkg::VocabSize];
  logic [15:0] doc_cnt  [lts_pkg::NumDocs*lts_pkg::NumTopics];

  request_t pending_reqs[$];
  result_t  expected_results[$];
  int       fail_count = 0;
  int       cycle_count = 0;

  int docs_used[3];
  int terms_used[3];

  function automatic logic [15:0] cnt_down(logic [15:0] c);
    return (c == 16'd0) ? 16'd0 : c - 16'd1;
  endfunction

  function automatic logic [15:0] cnt_up(logic [15:0] c);
    return (c == 16'hFFFF) ? 16'hFFFF : c + 16'd1;
  endfunction

  // Apply one accepted request to the shadow tables; queue its result if any.
  task automatic apply_request(request_t r);
    int          di, ti, chosen;
    logic [63:0] run, thresh;
    logic [63:0] cum [lts_pkg::NumTopics];
    result_t     res;
    bit          found;
    di = int'(r.doc) * lts_pkg::NumTopics + int'(r.topic);
    ti = int'(r.topic) * lts_pkg::VocabSize + int'(r.term);
    case (r.kind)
      lts_pkg::KIND_WR_DOC_WEIGHT:  doc_wt[di] = r.value;
      lts_pkg::KIND_WR_TERM_WEIGHT: term_wt[ti] = r.value;
      lts_pkg::KIND_WR_TERM_COUNT:  term_cnt[ti] = r.value;
      lts_pkg::KIND_WR_DOC_COUNT:   doc_cnt[di] = r.value;
      lts_pkg::KIND_READ: begin
        res.new_topic  = r.topic;
        res.picked     = 1'b0;
        res.term_count = term_cnt[ti];
        res.doc_count  = doc_cnt[di];
        expected_results = {expected_results, res};
      end
      lts_pkg::KIND_SAMPLE: begin
        term_cnt[ti] = cnt_down(term_cnt[ti]);
        doc_cnt[di]  = cnt_down(doc_cnt[di]);
        run = 64'd0;
        for (int k = 0; k < lts_pkg::NumTopics; k++) begin
          run += 64'(doc_wt[int'(r.doc) * lts_pkg::NumTopics + k]) *
                 64'(term_wt[k * lts_pkg::VocabSize + int'(r.term)]);
          cum[k] = run;
        end
        thresh = run * 64'(r.uniform);
        chosen = int'(r.topic);
        found  = 1'b0;
        for (int k = 0; k < lts_pkg::NumTopics; k++) begin
          if (!found && (cum[k] << 16) > thresh) begin
            chosen = k;
            found  = 1'b1;
          end
        end
        di = int'(r.doc) * lts_pkg::NumTopics + chosen;
        ti = chosen * lts_pkg::VocabSize + int'(r.term);
        term_cnt[ti] = cnt_up(term_cnt[ti]);
        doc_cnt[di]  = cnt_up(doc_cnt[di]);
        res.new_topic  = chosen[lts_pkg::TopicW-1:0];
        res.picked     = found;
        res.term_count = term_cnt[ti];
        res.doc_count  = doc_cnt[di];
        expected_results = {expected_results, res};
      end
      default: ;  // unused kinds: drop
    endcase
  endtask

  task automatic add_request(logic [2:0] kind, int term, int doc, int topic,
                             int value, int uniform, bit drain = 1'b0);
    request_t r;
    r.kind    = kind;
    r.term    = term[lts_pkg::TermW-1:0];
    r.doc     = doc[lts_pkg::DocW-1:0];
    r.topic   = topic[lts_pkg::TopicW-1:0];
    r.value   = value[lts_pkg::ValueW-1:0];
    r.uniform = uniform[lts_pkg::UniformW-1:0];
    r.drain   = drain;
    pending_reqs = {pending_reqs, r};
  endtask

  function automatic int pick_value();
    case ($urandom_range(0, 4))
      0:       return 0;
      1:       return 16'hFFFF;
      2:       return $urandom_range(0, 3);
      default: return $urandom_range(0, 16'hFFFF);
    endcase
  endfunction

  // Request driver.
  request_t cur_req;
  bit       req_busy = 1'b0;
  int       req_gap = 0;
  int       req_sent = 0;
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid   <= 1'b0;
      req_ch.kind    <= '0;
      req_ch.term    <= '0;
      req_ch.doc     <= '0;
      req_ch.topic   <= '0;
      req_ch.value   <= '0;
      req_ch.uniform <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        apply_request(cur_req);
        req_busy = 1'b0;
        req_gap = (((req_sent / 40) % 3) == 0) ? 0 : $urandom_range(0, 8);
      end
      if (!req_busy) begin
        if (req_gap > 0) begin
          req_gap--;
        end else if (pending_reqs.size() > 0 &&
                     (!pending_reqs[0].drain || expected_results.size() == 0)) begin
          cur_req = pending_reqs.pop_front();
          req_busy = 1'b1;
          req_sent++;
          req_ch.kind    <= cur_req.kind;
          req_ch.term    <= cur_req.term;
          req_ch.doc     <= cur_req.doc;
          req_ch.topic   <= cur_req.topic;
          req_ch.value   <= cur_req.value;
          req_ch.uniform <= cur_req.uniform;
        end
      end
      req_ch.valid <= req_busy;
    end
  end

  task automatic check_field(string name, int exp_v, int got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
      fail_count++;
    end
  endtask

  // Result monitor with random stalls and one long hold-off.
  int rsp_seen = 0;
  int rsp_stall = 0;
  int rsp_hold = 0;
  always @(posedge clk) begin
    result_t e;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual topic %0d", $time,
                   rsp_ch.new_topic);
          fail_count++;
        end else begin
          e = expected_results.pop_front();
          check_field("new_topic", e.new_topic, rsp_ch.new_topic);
          check_field("picked", e.picked, rsp_ch.picked);
          check_field("term_count", e.term_count, rsp_ch.term_count);
          check_field("doc_count", e.doc_count, rsp_ch.doc_count);
        end
        rsp_seen++;
        rsp_stall = (((rsp_seen / 30) % 3) == 1) ? 0 : $urandom_range(0, 8);
        if (rsp_seen == 80) rsp_hold = LongHold;
      end
      if (rsp_hold > 0) begin
        rsp_hold--;
        rsp_ch.ready <= 1'b0;
      end else if (rsp_stall > 0) begin
        rsp_stall--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int d, t, k;
    docs_used  = '{0, 255, $urandom_range(1, 254)};
    terms_used = '{0, 1023, $urandom_range(1, 1022)};

    // Load every entry that samples and reads will touch.
    foreach (docs_used[i]) begin
      d = docs_used[i];
      for (k = 0; k < lts_pkg::NumTopics; k++) begin
        add_request(lts_pkg::KIND_WR_DOC_WEIGHT, $urandom_range(0, 1023), d, k,
                    (d == 255) ? int'(k < 2) : (d == 0) ? 0 : pick_value(), $urandom);
        add_request(lts_pkg::KIND_WR_DOC_COUNT, $urandom_range(0, 1023), d, k,
                    $urandom_range(0, 3), $urandom);
      end
    end
    foreach (terms_used[i]) begin
      t = terms_used[i];
      for (k = 0; k < lts_pkg::NumTopics; k++) begin
        add_request(lts_pkg::KIND_WR_TERM_WEIGHT, t, $urandom_range(0, 255), k,
                    (t == 1023) ? 1 : pick_value(), $urandom);
        add_request(lts_pkg::KIND_WR_TERM_COUNT, t, $urandom_range(0, 255), k,
                    $urandom_range(0, 3), $urandom);
      end
    end

    // Directed: first topic, tie passed to the next topic, top of the draw.
    add_request(lts_pkg::KIND_SAMPLE, 1023, 255, 5, 0, 0);
    add_request(lts_pkg::KIND_SAMPLE, 1023, 255, 5, 0, 16'h8000);
    add_request(lts_pkg::KIND_SAMPLE, 1023, 255, 5, 0, 16'hFFFF);
    // Zero total keeps the old topic; a zero count ends at one.
    add_request(lts_pkg::KIND_SAMPLE, 0, 0, 15, 0, $urandom_range(0, 16'hFFFF));
    add_request(lts_pkg::KIND_WR_TERM_COUNT, 0, 0, 3, 0, 0);
    add_request(lts_pkg::KIND_WR_DOC_COUNT, 0, 0, 3, 0, 0);
    add_request(lts_pkg::KIND_SAMPLE, 0, 0, 3, 16'hFFFF, 16'hFFFF);
    add_request(lts_pkg::KIND_READ, 0, 0, 3, 0, 0);
    // Increment at full scale holds.
    add_request(lts_pkg::KIND_WR_TERM_COUNT, 1023, 255, 1, 16'hFFFF, 0);
    add_request(lts_pkg::KIND_WR_DOC_COUNT, 1023, 255, 1, 16'hFFFF, 0);
    add_request(lts_pkg::KIND_SAMPLE, 1023, 255, 0, 0, 16'hFFFF);
    add_request(lts_pkg::KIND_READ, 1023, 255, 1, 0, 0);
    // Full-scale weights.
    add_request(lts_pkg::KIND_WR_DOC_WEIGHT, 0, docs_used[2], 0, 16'hFFFF, 0);
    add_request(lts_pkg::KIND_WR_TERM_WEIGHT, terms_used[2], 0, 0, 16'hFFFF, 0);
    add_request(lts_pkg::KIND_SAMPLE, terms_used[2], docs_used[2], 15, 0, 16'hFFFF);
    add_request(lts_pkg::KIND_SAMPLE, terms_used[2], docs_used[2], 15, 0, 0);
    add_request(3'd6, 1023, 255, 15, 16'hFFFF, 16'hFFFF);
    add_request(3'd7, 0, 0, 0, 0, 0);

    for (int n = 0; n < RandItems; n++) begin
      int sel;
      bit drain;
      sel   = $urandom_range(0, 99);
      drain = (n == RandItems / 2);
      d = docs_used[$urandom_range(0, 2)];
      t = terms_used[$urandom_range(0, 2)];
      if (sel < 55) begin
        add_request(lts_pkg::KIND_SAMPLE, t, d, $urandom_range(0, 15), $urandom,
                    $urandom_range(0, 16'hFFFF), drain);
      end else if (sel < 70) begin
        add_request(lts_pkg::KIND_READ, t, d, $urandom_range(0, 15), $urandom, $urandom,
                    drain);
      end else if (sel < 95) begin
        if ($urandom_range(0, 4) == 0) begin
          d = $urandom_range(0, 255);
          t = $urandom_range(0, 1023);
        end
        add_request($urandom_range(lts_pkg::KIND_WR_DOC_WEIGHT, lts_pkg::KIND_WR_DOC_COUNT),
                    t, d, $urandom_range(0, 15), pick_value(), $urandom, drain);
      end else begin
        add_request($urandom_range(6, 7), $urandom, $urandom, $urandom, $urandom,
                    $urandom, drain);
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() > 0 || req_busy || expected_results.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/lts_pkg.sv
hw/rtl/lts_if.sv
hw/rtl/lts_ctrl.sv
hw/rtl/lts_datapath.sv
hw/rtl/lda_topic_gibbs_sampler.sv
hw/rtl/lts_checker.sv
tb/sv/lda_topic_gibbs_sampler_tb.sv
